[design/assert_macros.svh]
// Assertion helpers used by the RTL. Clock is clk, reset is rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ONWM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ONWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ONWM_ASSERT(lbl, prop)
`define ONWM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/onwm_pkg.sv]
`timescale 1ns / 1ps
package onwm_pkg;
    localparam int MAX_REF_NOTES = 1024;
    localparam int IDX_W = $clog2(MAX_REF_NOTES);
    localparam int FILL_W = $clog2(MAX_REF_NOTES + 1);
    localparam int CORR_FRAC = 12;
    localparam int REF_INDEX_W = 10;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_USER  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [2:0] ST_LOADED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_MATCHED   = 3'd2;
    localparam logic [2:0] ST_MISSED    = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_CORR   = 2'd1;
    localparam logic [1:0] CFG_ALIGN  = 2'd2;

    localparam logic signed [39:0] D40_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] D40_MIN = {1'b1, {39{1'b0}}};

    typedef struct packed {
        logic [6:0]  pitch;
        logic [3:0]  chan;
        logic [31:0] onset;
    } ref_entry_t;

    typedef struct packed {
        logic clr;
        logic match1;
        logic match2;
        logic miss;
        logic exh;
    } tally_cmd_t;
endpackage

[design/note_onset_window_matcher.sv]
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// input     start / busy       command, note_pitch, note_channel, onset_us
// result    done (strobe)      status, ref_index, delta_us, tallies
// config    cfg_we             cfg_addr, cfg_wdata
//
// A transfer is taken when start is high and busy is low; busy stays high
// until the result. A user note scans the table one entry at a time (single
// read port, registered read: a read state, then an evaluate state), or takes
// the cursor entry blindly when the window is zero; it then walks the cursor
// past taken entries and scales and tallies the delta (MUL, SCALE, TAL1, TAL2).
// Command 3 is accepted and dropped with no done pulse.
// rst_n is asynchronous; the note table needs no clearing. The receiver
// cannot stall: done is high for exactly one cycle per result.
module note_onset_window_matcher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          command,
    input  logic [6:0]          note_pitch,
    input  logic [4:0]          note_channel,
    input  logic [31:0]         onset_us,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [19:0]         cfg_wdata,
    output logic                done,
    output logic [2:0]          status,
    output logic [9:0]          ref_index,
    output logic signed [39:0]  delta_us,
    output logic [23:0]         matched_count,
    output logic [23:0]         missed_count,
    output logic [23:0]         exhausted_count,
    output logic signed [39:0]  delta_min,
    output logic signed [39:0]  delta_max,
    output logic signed [47:0]  delta_sum,
    output logic [47:0]         delta_abs_sum
);
    import onwm_pkg::*;
    `include "assert_macros.svh"

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_PREP    = 4'd2;
    localparam logic [3:0] S_SCAN_RD = 4'd3;
    localparam logic [3:0] S_SCAN_EV = 4'd4;
    localparam logic [3:0] S_SEL     = 4'd5;
    localparam logic [3:0] S_ADV_RD  = 4'd6;
    localparam logic [3:0] S_ADV_EV  = 4'd7;
    localparam logic [3:0] S_MUL     = 4'd8;
    localparam logic [3:0] S_SCALE   = 4'd9;
    localparam logic [3:0] S_TAL1    = 4'd10;
    localparam logic [3:0] S_TAL2    = 4'd11;

    logic [3:0]               state_reg, state_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic [6:0]               pitch_reg, pitch_next;
    logic [3:0]               chan_reg, chan_next;
    logic [31:0]              onset_reg, onset_next;
    logic [19:0]              window_reg, window_next;
    logic signed [15:0]       corr_reg, corr_next;
    logic                     align_reg, align_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [FILL_W-1:0]        cursor_reg, cursor_next;
    logic [31:0]              origin_reg, origin_next;
    logic                     origin_valid_reg, origin_valid_next;
    logic [31:0]              ref0_reg, ref0_next;
    logic signed [32:0]       ut_reg, ut_next;
    logic signed [33:0]       k_reg, k_next;
    logic [FILL_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]         first_reg, first_next;
    logic                     first_valid_reg, first_valid_next;
    logic [IDX_W-1:0]         sel_reg, sel_next;
    logic                     sel_valid_reg, sel_valid_next;
    logic [33:0]              best_dist_reg, best_dist_next;
    logic signed [33:0]       best_d_reg, best_d_next;
    logic                     blind_reg, blind_next;
    logic signed [49:0]       prod_reg, prod_next;
    logic signed [39:0]       delta_reg, delta_next;
    logic                     done_reg, done_next;
    logic [2:0]               status_reg, status_next;
    logic [9:0]               ref_index_reg, ref_index_next;
    logic signed [39:0]       delta_out_reg, delta_out_next;

    // table port
    logic                     wr_en;
    ref_entry_t               wr_data;
    logic                     tk_wr_en;
    logic [IDX_W-1:0]         tk_wr_addr;
    logic                     tk_wr_val;
    logic [IDX_W-1:0]         rd_addr;
    ref_entry_t               rd_data;
    logic                     rd_taken;
    tally_cmd_t               tcmd;

    // scan datapath: one subtract against the precomputed offset
    logic signed [33:0]       d;
    logic signed [33:0]       wpos;
    logic [33:0]              absd;
    logic                     below;
    logic                     above;
    logic                     hit;
    logic [31:0]              origin_eff;
    logic [FILL_W-1:0]        idx_inc;

    assign wpos  = $signed({14'd0, window_reg});
    assign d     = $signed({2'b00, rd_data.onset}) - k_reg;
    assign absd  = d[33] ? 34'(-d) : 34'(d);
    assign below = d < -wpos;
    assign above = d > wpos;
    assign hit   = (rd_data.pitch == pitch_reg) && (rd_data.chan == chan_reg);
    assign idx_inc = idx_reg + FILL_W'(1);
    assign origin_eff = origin_valid_reg ? origin_reg : onset_reg;

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        pitch_next        = pitch_reg;
        chan_next         = chan_reg;
        onset_next        = onset_reg;
        window_next       = window_reg;
        corr_next         = corr_reg;
        align_next        = align_reg;
        fill_next         = fill_reg;
        cursor_next       = cursor_reg;
        origin_next       = origin_reg;
        origin_valid_next = origin_valid_reg;
        ref0_next         = ref0_reg;
        ut_next           = ut_reg;
        k_next            = k_reg;
        idx_next          = idx_reg;
        first_next        = first_reg;
        first_valid_next  = first_valid_reg;
        sel_next          = sel_reg;
        sel_valid_next    = sel_valid_reg;
        best_dist_next    = best_dist_reg;
        best_d_next       = best_d_reg;
        blind_next        = blind_reg;
        prod_next         = prod_reg;
        delta_next        = delta_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        ref_index_next    = ref_index_reg;
        delta_out_next    = delta_out_reg;
        wr_en             = 1'b0;
        wr_data           = '{pitch: pitch_reg, chan: chan_reg, onset: onset_reg};
        tk_wr_en          = 1'b0;
        tk_wr_addr        = fill_reg[IDX_W-1:0];
        tk_wr_val         = 1'b0;
        rd_addr           = idx_reg[IDX_W-1:0];
        tcmd              = '0;

        // configuration writes, idle only by contract
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_WINDOW: window_next = cfg_wdata;
                CFG_CORR:   corr_next   = $signed(cfg_wdata[15:0]);
                CFG_ALIGN:  align_next  = cfg_wdata[0];
                default:    ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    pitch_next = note_pitch;
                    chan_next  = 4'(note_channel[3:0] - 4'd1);
                    onset_next = onset_us;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                status_next    = ST_LOADED;
                ref_index_next = '0;
                delta_out_next = '0;
                state_next     = S_IDLE;
                case (cmd_reg)
                    CMD_LOAD:
                    begin
                        done_next = 1'b1;
                        if (fill_reg >= FILL_W'(MAX_REF_NOTES))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            tk_wr_en  = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                            if (fill_reg == '0)
                            begin
                                ref0_next = onset_reg;
                            end
                        end
                    end
                    CMD_CLEAR:
                    begin
                        done_next         = 1'b1;
                        status_next       = ST_CLEARED;
                        tcmd.clr          = 1'b1;
                        fill_next         = '0;
                        cursor_next       = '0;
                        origin_next       = '0;
                        origin_valid_next = 1'b0;
                    end
                    CMD_USER:
                    begin
                        origin_next       = origin_eff;
                        origin_valid_next = 1'b1;
                        ut_next = $signed({1'b0, onset_reg})
                                - (align_reg ? $signed({1'b0, origin_eff}) : 33'sd0);
                        state_next = S_PREP;
                    end
                    default: ;
                endcase
            end
            S_PREP:
            begin
                k_next = {ut_reg[32], ut_reg}
                       + (align_reg ? $signed({2'b00, ref0_reg}) : 34'sd0);
                idx_next         = cursor_reg;
                first_valid_next = 1'b0;
                sel_valid_next   = 1'b0;
                blind_next       = (window_reg == '0);
                if (cursor_reg >= fill_reg)
                begin
                    tcmd.exh    = 1'b1;
                    status_next = ST_EXHAUSTED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (blind_reg)
                begin
                    sel_next       = idx_reg[IDX_W-1:0];
                    sel_valid_next = 1'b1;
                    best_d_next    = d;
                    state_next     = S_SEL;
                end
                else
                begin
                    logic stop;
                    stop = 1'b0;
                    if (!rd_taken && !below)
                    begin
                        if (!first_valid_reg)
                        begin
                            first_next       = idx_reg[IDX_W-1:0];
                            first_valid_next = 1'b1;
                        end
                        if (above)
                        begin
                            stop = 1'b1;
                        end
                        else if (hit && (!sel_valid_reg || absd < best_dist_reg))
                        begin
                            sel_next       = idx_reg[IDX_W-1:0];
                            sel_valid_next = 1'b1;
                            best_dist_next = absd;
                            best_d_next    = d;
                        end
                    end
                    if (idx_inc >= fill_reg)
                    begin
                        stop = 1'b1;
                    end
                    idx_next = idx_inc;
                    if (!stop)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (sel_valid_next)
                    begin
                        state_next = S_SEL;
                    end
                    else
                    begin
                        // miss: cursor jumps to the first entry reached
                        if (first_valid_next)
                        begin
                            cursor_next = {1'b0, first_next};
                        end
                        tcmd.miss   = 1'b1;
                        status_next = ST_MISSED;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_SEL:
            begin
                tk_wr_en   = 1'b1;
                tk_wr_addr = sel_reg;
                tk_wr_val  = 1'b1;
                state_next = S_ADV_RD;
            end
            S_ADV_RD:
            begin
                rd_addr = cursor_reg[IDX_W-1:0];
                state_next = (cursor_reg >= fill_reg) ? S_MUL : S_ADV_EV;
            end
            S_ADV_EV:
            begin
                if (rd_taken)
                begin
                    cursor_next = cursor_reg + FILL_W'(1);
                    state_next  = S_ADV_RD;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = best_d_reg * corr_reg;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                // arithmetic shift floors; result always fits 40 bits
                delta_next = 40'(prod_reg >>> CORR_FRAC);
                state_next = S_TAL1;
            end
            S_TAL1:
            begin
                tcmd.match1 = 1'b1;
                state_next  = S_TAL2;
            end
            S_TAL2:
            begin
                tcmd.match2    = 1'b1;
                status_next    = ST_MATCHED;
                ref_index_next = REF_INDEX_W'(sel_reg);
                delta_out_next = delta_reg;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_reg       <= 20'd60000;
            corr_reg         <= 16'sd4096;
            align_reg        <= 1'b1;
            fill_reg         <= '0;
            cursor_reg       <= '0;
            origin_reg       <= '0;
            origin_valid_reg <= 1'b0;
            first_valid_reg  <= 1'b0;
            sel_valid_reg    <= 1'b0;
            blind_reg        <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_reg       <= window_next;
            corr_reg         <= corr_next;
            align_reg        <= align_next;
            fill_reg         <= fill_next;
            cursor_reg       <= cursor_next;
            origin_reg       <= origin_next;
            origin_valid_reg <= origin_valid_next;
            first_valid_reg  <= first_valid_next;
            sel_valid_reg    <= sel_valid_next;
            blind_reg        <= blind_next;
            done_reg         <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pitch_reg     <= pitch_next;
        chan_reg      <= chan_next;
        onset_reg     <= onset_next;
        ref0_reg      <= ref0_next;
        ut_reg        <= ut_next;
        k_reg         <= k_next;
        idx_reg       <= idx_next;
        first_reg     <= first_next;
        sel_reg       <= sel_next;
        best_dist_reg <= best_dist_next;
        best_d_reg    <= best_d_next;
        prod_reg      <= prod_next;
        delta_reg     <= delta_next;
        status_reg    <= status_next;
        ref_index_reg <= ref_index_next;
        delta_out_reg <= delta_out_next;
    end

    onwm_table u_table (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (fill_reg[IDX_W-1:0]),
        .wr_data    (wr_data),
        .tk_wr_en   (tk_wr_en),
        .tk_wr_addr (tk_wr_addr),
        .tk_wr_val  (tk_wr_val),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .rd_taken   (rd_taken)
    );

    onwm_tally u_tally (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (tcmd),
        .delta           (delta_reg),
        .matched_count   (matched_count),
        .missed_count    (missed_count),
        .exhausted_count (exhausted_count),
        .delta_min       (delta_min),
        .delta_max       (delta_max),
        .delta_sum       (delta_sum),
        .delta_abs_sum   (delta_abs_sum)
    );

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign ref_index = ref_index_reg;
    assign delta_us  = delta_out_reg;

    `ONWM_ASSERT(a_done_not_busy, !(done && busy))
    `ONWM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `ONWM_ASSERT(a_cursor_in_fill, cursor_reg <= fill_reg)
    `ONWM_ASSERT(a_fill_bound, fill_reg <= FILL_W'(MAX_REF_NOTES))
endmodule

[design/onwm_table.sv]
`timescale 1ns / 1ps
module onwm_table (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [onwm_pkg::IDX_W-1:0]  wr_addr,
    input  onwm_pkg::ref_entry_t        wr_data,
    input  logic                        tk_wr_en,
    input  logic [onwm_pkg::IDX_W-1:0]  tk_wr_addr,
    input  logic                        tk_wr_val,
    input  logic [onwm_pkg::IDX_W-1:0]  rd_addr,
    output onwm_pkg::ref_entry_t        rd_data,
    output logic                        rd_taken
);
    import onwm_pkg::*;

    ref_entry_t entry_mem [MAX_REF_NOTES];
    logic       taken_mem [MAX_REF_NOTES];

    // note table, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data <= entry_mem[rd_addr];
    end

    // taken flags: cleared when an entry loads, set on a match
    always_ff @(posedge clk)
    begin
        if (tk_wr_en)
        begin
            taken_mem[tk_wr_addr] <= tk_wr_val;
        end
        rd_taken <= taken_mem[rd_addr];
    end
endmodule

[design/onwm_tally.sv]
`timescale 1ns / 1ps
module onwm_tally (
    input  logic                 clk,
    input  logic                 rst_n,
    input  onwm_pkg::tally_cmd_t cmd,
    input  logic signed [39:0]   delta,
    output logic [23:0]          matched_count,
    output logic [23:0]          missed_count,
    output logic [23:0]          exhausted_count,
    output logic signed [39:0]   delta_min,
    output logic signed [39:0]   delta_max,
    output logic signed [47:0]   delta_sum,
    output logic [47:0]          delta_abs_sum
);
    import onwm_pkg::*;

    logic [23:0]        cnt_m_reg, cnt_m_next;
    logic [23:0]        cnt_x_reg, cnt_x_next;
    logic [23:0]        cnt_e_reg, cnt_e_next;
    logic signed [39:0] min_reg, min_next;
    logic signed [39:0] max_reg, max_next;
    logic signed [47:0] sum_reg, sum_next;
    logic [47:0]        abs_reg, abs_next;
    logic signed [48:0] sum_wide;
    logic [48:0]        abs_wide;
    logic [39:0]        mag;

    always_comb
    begin
        cnt_m_next = cnt_m_reg;
        cnt_x_next = cnt_x_reg;
        cnt_e_next = cnt_e_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        abs_next   = abs_reg;
        sum_wide   = {sum_reg[47], sum_reg} + 49'(delta);
        mag        = delta[39] ? 40'(-delta) : 40'(delta);
        abs_wide   = {1'b0, abs_reg} + {9'd0, mag};
        if (cmd.clr)
        begin
            cnt_m_next = '0;
            cnt_x_next = '0;
            cnt_e_next = '0;
            min_next   = D40_MAX;
            max_next   = D40_MIN;
            sum_next   = '0;
            abs_next   = '0;
        end
        else
        begin
            // first half of a match: count, sum, minimum
            if (cmd.match1)
            begin
                if (cnt_m_reg != '1)
                begin
                    cnt_m_next = cnt_m_reg + 24'd1;
                end
                if (delta < min_reg)
                begin
                    min_next = delta;
                end
                if (sum_wide[48] != sum_wide[47])
                begin
                    sum_next = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                end
                else
                begin
                    sum_next = sum_wide[47:0];
                end
            end
            // second half: absolute sum, maximum
            if (cmd.match2)
            begin
                if (delta > max_reg)
                begin
                    max_next = delta;
                end
                abs_next = abs_wide[48] ? '1 : abs_wide[47:0];
            end
            if (cmd.miss && cnt_x_reg != '1)
            begin
                cnt_x_next = cnt_x_reg + 24'd1;
            end
            if (cmd.exh && cnt_e_reg != '1)
            begin
                cnt_e_next = cnt_e_reg + 24'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_m_reg <= '0;
            cnt_x_reg <= '0;
            cnt_e_reg <= '0;
            min_reg   <= D40_MAX;
            max_reg   <= D40_MIN;
            sum_reg   <= '0;
            abs_reg   <= '0;
        end
        else
        begin
            cnt_m_reg <= cnt_m_next;
            cnt_x_reg <= cnt_x_next;
            cnt_e_reg <= cnt_e_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            abs_reg   <= abs_next;
        end
    end

    assign matched_count   = cnt_m_reg;
    assign missed_count    = cnt_x_reg;
    assign exhausted_count = cnt_e_reg;
    assign delta_min       = min_reg;
    assign delta_max       = max_reg;
    assign delta_sum       = sum_reg;
    assign delta_abs_sum   = abs_reg;
endmodule

[sim/note_onset_window_matcher_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the note onset window matcher.
// Directed rows first, then random practice sessions scored by a
// behavioral score model.
module note_onset_window_matcher_tb;
    import onwm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 650;
    localparam int QUIET_TAIL     = 100;    // last items go without idling

    typedef struct {
        logic [2:0]         status;
        logic [9:0]         idx;
        logic signed [39:0] delta;
        logic [23:0]        n_match;
        logic [23:0]        n_miss;
        logic [23:0]        n_exh;
        logic signed [39:0] d_min;
        logic signed [39:0] d_max;
        logic signed [47:0] d_sum;
        logic [47:0]        d_abs;
    } score_t;

    // directed row: either a register write or a command transfer,
    // optionally with status/index/delta typed in by hand
    typedef struct {
        bit                 is_cfg;
        logic [1:0]         code;     // command, or register index
        logic [6:0]         pitch;
        logic [4:0]         chan;
        logic [31:0]        value;    // onset, or register data
        bit                 typed;
        logic [2:0]         st;
        logic [9:0]         idx;
        longint             delta;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         command = CMD_NONE;
    logic [6:0]         note_pitch = '0;
    logic [4:0]         note_channel = '0;
    logic [31:0]        onset_us = '0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_addr = '0;
    logic [19:0]        cfg_wdata = '0;
    logic               done;
    logic [2:0]         status;
    logic [9:0]         ref_index;
    logic signed [39:0] delta_us;
    logic [23:0]        matched_count;
    logic [23:0]        missed_count;
    logic [23:0]        exhausted_count;
    logic signed [39:0] delta_min;
    logic signed [39:0] delta_max;
    logic signed [47:0] delta_sum;
    logic [47:0]        delta_abs_sum;

    note_onset_window_matcher u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- score model state ----------------
    logic [6:0]         sm_pitch [MAX_REF_NOTES];
    logic [3:0]         sm_chan  [MAX_REF_NOTES];
    logic [31:0]        sm_onset [MAX_REF_NOTES];
    bit                 sm_taken [MAX_REF_NOTES];
    int                 sm_fill;
    int                 sm_cursor;
    logic [31:0]        sm_origin;
    bit                 sm_origin_ok;
    score_t             sm_tally;
    logic [19:0]        sm_window;
    logic signed [15:0] sm_corr;
    bit                 sm_align;

    score_t             pending_scores[$];
    int                 errors = 0;
    int                 items_sent = 0;
    int                 n_matched_seen = 0;
    int                 n_missed_seen = 0;
    int                 n_exh_seen = 0;

    function automatic void clear_session();
        for (int i = 0; i < MAX_REF_NOTES; i++)
            sm_taken[i] = 1'b0;
        sm_fill = 0;
        sm_cursor = 0;
        sm_origin = '0;
        sm_origin_ok = 1'b0;
        sm_tally = '{default: '0};
        sm_tally.d_min = D40_MAX;
        sm_tally.d_max = D40_MIN;
    endfunction

    function automatic logic [23:0] sat_inc(logic [23:0] c);
        return (c == 24'hFFFFFF) ? c : c + 24'd1;
    endfunction

    function automatic longint ref_time(int i);
        longint t;
        t = longint'({32'h0, sm_onset[i]});
        if (sm_align)
            t -= longint'({32'h0, sm_onset[0]});
        return t;
    endfunction

    // Q4.12 scale, floored, clamped to 40 bits
    function automatic longint scale_delta(longint raw);
        longint p;
        p = (raw * longint'(sm_corr)) >>> CORR_FRAC;
        if (p > longint'(D40_MAX)) p = longint'(D40_MAX);
        if (p < longint'(D40_MIN)) p = longint'(D40_MIN);
        return p;
    endfunction

    // advance the score model by one accepted transfer
    function automatic void score_note(logic [1:0] cmd, logic [6:0] p,
                                       logic [4:0] ch, logic [31:0] on);
        score_t     r;
        logic [3:0] c;
        longint     ut, w, rt, gap, best, d, s, a;
        int         sel, first;
        c = 4'(ch + 5'd15);
        sel = -1;
        if (cmd == CMD_NONE)
            return;
        r = sm_tally;
        r.idx = '0;
        r.delta = '0;
        if (cmd == CMD_LOAD) begin
            if (sm_fill >= MAX_REF_NOTES) begin
                r.status = ST_FULL;
            end else begin
                sm_pitch[sm_fill] = p;
                sm_chan[sm_fill] = c;
                sm_onset[sm_fill] = on;
                sm_taken[sm_fill] = 1'b0;
                sm_fill++;
                r.status = ST_LOADED;
            end
        end else if (cmd == CMD_CLEAR) begin
            clear_session();
            r = sm_tally;
            r.idx = '0;
            r.delta = '0;
            r.status = ST_CLEARED;
        end else begin
            if (!sm_origin_ok) begin
                sm_origin = on;
                sm_origin_ok = 1'b1;
            end
            ut = longint'({32'h0, on}) - (sm_align ? longint'({32'h0, sm_origin}) : 0);
            if (sm_cursor >= sm_fill) begin
                sm_tally.n_exh = sat_inc(sm_tally.n_exh);
                r.status = ST_EXHAUSTED;
            end else if (sm_window == 0) begin
                sel = sm_cursor;   // sequential mode: take cursor entry blindly
            end else begin
                w = longint'(sm_window);
                best = 0;
                first = -1;
                for (int i = sm_cursor; i < sm_fill; i++) begin
                    if (sm_taken[i])
                        continue;
                    rt = ref_time(i);
                    if (rt < ut - w)
                        continue;
                    if (first < 0)
                        first = i;
                    if (rt > ut + w)
                        break;
                    if (sm_pitch[i] != p || sm_chan[i] != c)
                        continue;
                    gap = (rt > ut) ? rt - ut : ut - rt;
                    if (sel < 0 || gap < best) begin
                        sel = i;
                        best = gap;
                    end
                end
                if (sel < 0) begin
                    if (first > sm_cursor)
                        sm_cursor = first;
                    sm_tally.n_miss = sat_inc(sm_tally.n_miss);
                    r.status = ST_MISSED;
                end
            end
            if (sel >= 0) begin
                sm_taken[sel] = 1'b1;
                while (sm_cursor < sm_fill && sm_taken[sm_cursor])
                    sm_cursor++;
                d = scale_delta(ref_time(sel) - ut);
                s = longint'(sm_tally.d_sum) + d;
                a = (d < 0) ? -d : d;
                sm_tally.n_match = sat_inc(sm_tally.n_match);
                if (d < longint'(sm_tally.d_min)) sm_tally.d_min = 40'(d);
                if (d > longint'(sm_tally.d_max)) sm_tally.d_max = 40'(d);
                if (s > 64'sd140737488355327) s = 64'sd140737488355327;
                if (s < -64'sd140737488355328) s = -64'sd140737488355328;
                sm_tally.d_sum = 48'(s);
                a = longint'({16'h0, sm_tally.d_abs}) + a;
                sm_tally.d_abs = (a > 64'sd281474976710655) ? 48'hFFFFFFFFFFFF : 48'(a);
                r.status = ST_MATCHED;
                r.idx = 10'(sel);
                r.delta = 40'(d);
            end
            r.n_match = sm_tally.n_match;
            r.n_miss = sm_tally.n_miss;
            r.n_exh = sm_tally.n_exh;
            r.d_min = sm_tally.d_min;
            r.d_max = sm_tally.d_max;
            r.d_sum = sm_tally.d_sum;
            r.d_abs = sm_tally.d_abs;
        end
        if (cmd == CMD_LOAD) begin
            r.n_match = sm_tally.n_match;
        end
        pending_scores = {pending_scores, r};
    endfunction

    // ---------------- result checking ----------------
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    int idle_cycles = 0;

    always @(posedge clk)
    begin
        score_t e;
        if (rst_n) begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, no transfer for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end else if (done) begin
                if (pending_scores.size() == 0) begin
                    errors++;
                    $display("%0t: result with no expectation, status %0d", $time, status);
                end else begin
                    e = pending_scores.pop_front();
                    case (e.status)
                        ST_MATCHED:   n_matched_seen++;
                        ST_MISSED:    n_missed_seen++;
                        ST_EXHAUSTED: n_exh_seen++;
                        default: ;
                    endcase
                    check_field("status", e.status, status);
                    check_field("ref_index", e.idx, ref_index);
                    check_field("delta_us", e.delta, delta_us);
                    check_field("matched_count", e.n_match, matched_count);
                    check_field("missed_count", e.n_miss, missed_count);
                    check_field("exhausted_count", e.n_exh, exhausted_count);
                    check_field("delta_min", e.d_min, delta_min);
                    check_field("delta_max", e.d_max, delta_max);
                    check_field("delta_sum", e.d_sum, delta_sum);
                    check_field("delta_abs_sum", e.d_abs, delta_abs_sum);
                end
            end
        end
    end

    // ---------------- driving ----------------
    bit quiet = 1'b0;

    // one command transfer; start stays high for back-to-back items
    task automatic send_note(logic [1:0] cmd, logic [6:0] p, logic [4:0] ch,
                             logic [31:0] on);
        start <= 1'b1;
        command <= cmd;
        note_pitch <= p;
        note_channel <= ch;
        onset_us <= on;
        do @(posedge clk); while (busy);
        score_note(cmd, p, ch, on);
        items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // hold off until every result is in and the block has settled
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        wait (pending_scores.size() == 0);
        while (busy) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [19:0] data);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            CFG_WINDOW: sm_window = data;
            CFG_CORR:   sm_corr = data[15:0];
            CFG_ALIGN:  sm_align = data[0];
            default: ;
        endcase
    endtask

    // ---------------- directed table ----------------
    row_t rows[$];

    task automatic add_cmd(logic [1:0] cmd, logic [6:0] p, logic [4:0] ch, logic [31:0] on,
                           bit typed = 0, logic [2:0] st = ST_LOADED,
                           logic [9:0] idx = '0, longint d = 0);
        row_t r;
        r = '{1'b0, cmd, p, ch, on, typed, st, idx, d};
        rows = {rows, r};
    endtask

    task automatic add_cfg(logic [1:0] addr, logic [31:0] data);
        row_t r;
        r = '{1'b1, addr, 7'd0, 5'd0, data, 1'b0, ST_LOADED, 10'd0, 0};
        rows = {rows, r};
    endtask

    task automatic run_directed();
        int last;
        // reset settings: 60 ms window, unity correction, aligned
        add_cmd(CMD_USER, 7'd3, 5'd1, 32'd1000, 1, ST_EXHAUSTED);   // empty table
        add_cmd(CMD_CLEAR, 7'd0, 5'd0, 32'd0, 1, ST_CLEARED);
        add_cmd(CMD_LOAD, 7'd0, 5'd1, 32'd0, 1, ST_LOADED);
        add_cmd(CMD_LOAD, 7'd127, 5'd16, 32'd50000, 1, ST_LOADED);
        add_cmd(CMD_LOAD, 7'd60, 5'd0, 32'd100000, 1, ST_LOADED);   // channel 0 = 16
        add_cmd(CMD_LOAD, 7'd5, 5'd17, 32'hFFFFFFFF, 1, ST_LOADED); // 17 wraps to 1
        add_cmd(CMD_USER, 7'd0, 5'd1, 32'd5000, 1, ST_MATCHED, 10'd0, 0);
        add_cmd(CMD_USER, 7'd60, 5'd16, 32'd105000, 1, ST_MATCHED, 10'd2, 0);
        add_cmd(CMD_USER, 7'd127, 5'd16, 32'd56000, 1, ST_MATCHED, 10'd1, -1000);
        add_cmd(CMD_USER, 7'd5, 5'd1, 32'd5000, 1, ST_MISSED);       // ref far ahead
        add_cmd(CMD_USER, 7'd5, 5'd1, 32'hFFFFFFFF, 1, ST_MATCHED, 10'd3, 5000);
        add_cmd(CMD_USER, 7'd5, 5'd1, 32'd7, 1, ST_EXHAUSTED);
        add_cmd(CMD_NONE, 7'd127, 5'd31, 32'hFFFFFFFF);              // dropped
        // sequential mode, most negative correction, no alignment
        add_cfg(CFG_WINDOW, 32'd0);
        add_cfg(CFG_CORR, 32'h8000);
        add_cfg(CFG_ALIGN, 32'd0);
        add_cmd(CMD_CLEAR, 7'd0, 5'd0, 32'd0, 1, ST_CLEARED);
        add_cmd(CMD_LOAD, 7'd1, 5'd2, 32'hFFFFFFFF, 1, ST_LOADED);
        add_cmd(CMD_LOAD, 7'd1, 5'd2, 32'd0, 1, ST_LOADED);
        add_cmd(CMD_USER, 7'd9, 5'd3, 32'd0, 1, ST_MATCHED, 10'd0, -64'sd34359738360);
        add_cmd(CMD_USER, 7'd9, 5'd3, 32'hFFFFFFFF, 1, ST_MATCHED, 10'd1, 64'sd34359738360);
        add_cmd(CMD_USER, 7'd9, 5'd3, 32'd0, 1, ST_EXHAUSTED);
        // idle gaps come after the typed values are in place
        quiet = 1'b1;
        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                write_reg(rows[k].code, rows[k].value[19:0]);
            end else begin
                send_note(rows[k].code, rows[k].pitch, rows[k].chan, rows[k].value);
                // hand-typed status/index/delta take the place of the model's
                if (rows[k].typed) begin
                    last = pending_scores.size() - 1;
                    pending_scores[last].status = rows[k].st;
                    pending_scores[last].idx = rows[k].idx;
                    pending_scores[last].delta = 40'(rows[k].delta);
                end
                if ($urandom_range(0, 3) == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
            end
        end
        quiet = 1'b0;
    endtask

    // ---------------- random sessions ----------------
    task automatic random_config();
        logic [19:0] w;
        case ($urandom_range(0, 4))
            0: w = 20'd0;
            1: w = 20'hFFFFF;
            2: w = 20'd60000;
            default: w = 20'($urandom_range(1, 200000));
        endcase
        write_reg(CFG_WINDOW, w);
        case ($urandom_range(0, 4))
            0: write_reg(CFG_CORR, 20'h07FFF);
            1: write_reg(CFG_CORR, 20'h08000);
            2: write_reg(CFG_CORR, 20'h01000);
            default: write_reg(CFG_CORR, 20'($urandom_range(0, 65535)));
        endcase
        write_reg(CFG_ALIGN, 20'($urandom_range(0, 1)));
    endtask

    // a clear, a reference passage, then a performance of it with timing jitter
    task automatic play_session(int n_refs);
        logic [31:0] ref_on[$];
        logic [6:0]  ref_p[$];
        logic [4:0]  ref_c[$];
        longint      t, jw, j, u;
        logic [31:0] user_base;
        int          roll;
        send_note(CMD_CLEAR, 7'($urandom), 5'($urandom), $urandom);
        t = $urandom_range(0, 3) == 0 ? longint'($urandom) : $urandom_range(0, 100000);
        for (int i = 0; i < n_refs; i++) begin
            if (t > 64'hFFFFFFFF) t = 64'hFFFFFFFF;
            ref_on = {ref_on, 32'(t)};
            ref_p = {ref_p, ($urandom_range(0, 7) == 0 ? 7'($urandom)
                                                       : 7'($urandom_range(60, 63)))};
            ref_c = {ref_c, ($urandom_range(0, 7) == 0 ? 5'($urandom)
                                                       : 5'($urandom_range(1, 2)))};
            send_note(CMD_LOAD, ref_p[i], ref_c[i], ref_on[i]);
            t += $urandom_range(0, 80000);
        end
        jw = (sm_window == 0) ? 50000 : longint'(sm_window);
        if (jw > 200000) jw = 200000;
        user_base = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 5000));
        for (int i = 0; i < n_refs + 2; i++) begin
            roll = $urandom_range(0, 19);
            if (i >= n_refs || roll == 0) begin
                send_note(CMD_USER, 7'($urandom), 5'($urandom), $urandom);
                continue;
            end
            if (roll == 1) begin
                send_note(CMD_NONE, 7'($urandom), 5'($urandom), $urandom);
                continue;
            end
            if (roll == 2) begin
                // late addition to the passage while playing
                send_note(CMD_LOAD, ref_p[i], ref_c[i], ref_on[n_refs - 1] + 32'd1000);
                continue;
            end
            if (roll == 3)
                continue;                       // note left out by the player
            j = longint'($urandom_range(0, 32'(3 * jw))) - (3 * jw) / 2;
            if (sm_align)
                u = longint'({32'h0, user_base})
                    + longint'({32'h0, ref_on[i]}) - longint'({32'h0, ref_on[0]}) + j;
            else
                u = longint'({32'h0, ref_on[i]}) + j;
            send_note(CMD_USER, roll == 4 ? 7'(ref_p[i] + 7'd1) : ref_p[i],
                      ref_c[i], 32'(u));
        end
    endtask

    initial
    begin
        int sessions;
        sessions = 0;
        clear_session();
        sm_window = 20'd60000;
        sm_corr = 16'sd4096;
        sm_align = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        while (items_sent < RANDOM_ITEMS) begin
            if (sessions % 3 == 0)
                random_config();
            else if ($urandom_range(0, 1) == 0)
                drain();                        // sender waits for all results
            quiet = (items_sent > RANDOM_ITEMS - QUIET_TAIL);
            play_session($urandom_range(0, 9) == 0 ? $urandom_range(40, 60)
                                                    : $urandom_range(1, 20));
            sessions++;
        end

        start <= 1'b0;
        wait (pending_scores.size() == 0);
        repeat (20) @(posedge clk);
        $display("Covered %0d transfers: directed edge rows and %0d random sessions.",
                 items_sent, sessions);
        $display("Results: %0d matched, %0d missed, %0d exhausted, %0d errors.",
                 n_matched_seen, n_missed_seen, n_exh_seen, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
